[rtl/core/substring_contains_matcher_top_defines.svh]
// Assertion helpers shared by the matcher modules.
// Each expects clk and rst_n in scope.
`ifndef SUBSTRING_CONTAINS_MATCHER_TOP_DEFINES_SVH
`define SUBSTRING_CONTAINS_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SCM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/scm_pkg.sv]
package scm_pkg;

    localparam int NEEDLE_MAX_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int CFG_W          = 64;
    localparam int NEEDLE_WORDS   = 4;
    localparam int NEEDLE_W       = NEEDLE_WORDS * CFG_W;
    localparam int LEN_W          = 6;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_0_7,
        REG_NEEDLE_8_15,
        REG_NEEDLE_16_23,
        REG_NEEDLE_24_31,
        REG_NEEDLE_LENGTH,
        REG_CASE_SENSITIVE
    } cfg_reg_t;

    // Live configuration seen by the compare logic.
    typedef struct packed {
        logic [NEEDLE_W-1:0] needle;
        logic [LEN_W-1:0]    length;
        logic                case_sensitive;
    } cfg_t;

    // One item leaving the input stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] text_byte;
        logic              byte_present;
        logic              end_of_string;
    } step_t;

endpackage

[rtl/core/scm_channel_if.sv]
interface scm_text_if import scm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              byte_present;
    logic              end_of_string;

    modport source (output valid, output text_byte, output byte_present,
                    output end_of_string, input ready);
    modport sink (input valid, input text_byte, input byte_present,
                  input end_of_string, output ready);
endinterface

interface scm_result_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink (input valid, input found, output ready);
endinterface

[rtl/core/substring_contains_matcher_top.sv]
// Substring matcher: streams haystack bytes, one per transaction, and on the
// transaction flagged end_of_string returns one result telling whether the
// configured needle (0 to NEEDLE_MAX bytes, optional ASCII case folding)
// occurred in that string. A transaction with neither a byte nor an end marker
// is absorbed without effect; an empty string is a lone end marker. The block
// takes one transaction per cycle; an end marker passes the stage register
// and then the output register. The parallel compare of the needle against
// the current byte and a shift line of earlier bytes is combinational.
// A result waiting on the output holds back only a further end marker.
// Configuration writes take effect at once and belong between transactions.
`include "substring_contains_matcher_top_defines.svh"

module substring_contains_matcher_top
    import scm_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    scm_text_if.sink             haystack,
    scm_result_if.source         verdict,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int WIN_D = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

    logic [CFG_W-1:0]  needle_reg [NEEDLE_WORDS];
    logic [LEN_W-1:0]  length_reg;
    logic              case_sensitive_reg;
    cfg_t              cfg;

    logic              stage_valid_reg;
    logic [BYTE_W-1:0] stage_byte_reg;
    logic              stage_present_reg;
    logic              stage_last_reg;
    logic              out_valid_reg;
    logic              found_reg;
    logic              found_next;

    logic              out_free;
    logic              advance;
    logic              accept;
    step_t             step;
    logic              hit;
    logic              match_next;
    logic [BYTE_W-1:0] window [WIN_D];
    logic [LEN_W-1:0]  bytes_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NEEDLE_WORDS; w++)
            begin
                needle_reg[w] <= '0;
            end
            length_reg         <= '0;
            case_sensitive_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NEEDLE_0_7:     needle_reg[0]      <= cfg_data;
                REG_NEEDLE_8_15:    needle_reg[1]      <= cfg_data;
                REG_NEEDLE_16_23:   needle_reg[2]      <= cfg_data;
                REG_NEEDLE_24_31:   needle_reg[3]      <= cfg_data;
                REG_NEEDLE_LENGTH:  length_reg         <= cfg_data[LEN_W-1:0];
                REG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        for (int w = 0; w < NEEDLE_WORDS; w++)
        begin
            cfg.needle[w*CFG_W +: CFG_W] = needle_reg[w];
        end
        cfg.length         = length_reg;
        cfg.case_sensitive = case_sensitive_reg;
    end

    // Only an end marker needs the output register; other items always drain.
    assign out_free       = !out_valid_reg || verdict.ready;
    assign advance        = stage_valid_reg && (!stage_last_reg || out_free);
    assign haystack.ready = !stage_valid_reg || advance;
    assign accept         = haystack.valid && haystack.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (haystack.ready)
        begin
            stage_valid_reg <= haystack.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg    <= haystack.text_byte;
            stage_present_reg <= haystack.byte_present;
            stage_last_reg    <= haystack.end_of_string;
        end
    end

    always_comb
    begin
        step.valid         = advance;
        step.text_byte     = stage_byte_reg;
        step.byte_present  = stage_present_reg;
        step.end_of_string = stage_last_reg;
    end

    scm_compare #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_compare (
        .cfg        (cfg),
        .cur_byte   (stage_byte_reg),
        .window     (window),
        .bytes_seen (bytes_seen),
        .hit        (hit)
    );

    scm_tracker #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .hit        (hit),
        .window     (window),
        .bytes_seen (bytes_seen),
        .match_next (match_next)
    );

    assign found_next = match_next || (length_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && stage_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_last_reg)
        begin
            found_reg <= found_next;
        end
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.found = found_reg;

    `SCM_ASSERT_NEXT(a_end_waits,
        stage_valid_reg && stage_last_reg && out_valid_reg && !verdict.ready,
        stage_valid_reg && stage_last_reg, "end marker dropped while output busy")
    `SCM_ASSERT_NEXT(a_empty_needle_found,
        advance && stage_last_reg && length_reg == '0,
        out_valid_reg && found_reg, "empty needle did not report found")
    `SCM_ASSERT_IMPLY(a_result_from_end, $rose(out_valid_reg),
        $past(advance && stage_last_reg), "result without an end marker")

endmodule

[rtl/core/scm_compare.sv]
module scm_compare
    import scm_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
    input  cfg_t              cfg,
    input  logic [BYTE_W-1:0] cur_byte,
    input  logic [BYTE_W-1:0] window [(NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1],
    input  logic [LEN_W-1:0]  bytes_seen,
    output logic              hit
);

    localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b,
                                               input logic exact);
        if (!exact && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

    logic [BYTE_W-1:0] hist    [NEEDLE_MAX];
    logic [LEN_W-1:0]  idx     [NEEDLE_MAX];
    logic [BYTE_W-1:0] aligned [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] pos_ok;

    // hist is newest first: the current byte, then the stored window.
    always_comb
    begin
        hist[0] = cur_byte;
        for (int j = 1; j < NEEDLE_MAX; j++)
        begin
            hist[j] = window[j-1];
        end
    end

    // Needle byte m lines up with the string byte length-1-m places back.
    always_comb
    begin
        for (int m = 0; m < NEEDLE_MAX; m++)
        begin
            idx[m]     = cfg.length - LEN_W'(m) - LEN_W'(1);
            aligned[m] = fold(hist[idx[m][IDX_W-1:0]], cfg.case_sensitive);
            pos_ok[m]  = (LEN_W'(m) >= cfg.length) ||
                         (aligned[m] == fold(cfg.needle[m*BYTE_W +: BYTE_W],
                                             cfg.case_sensitive));
        end
    end

    always_comb
    begin
        priority if (cfg.length == '0)
        begin
            hit = 1'b1;
        end
        else if (cfg.length > LEN_W'(NEEDLE_MAX))
        begin
            hit = 1'b0;
        end
        else if ((LEN_W+1)'(bytes_seen) + (LEN_W+1)'(1) < (LEN_W+1)'(cfg.length))
        begin
            hit = 1'b0;
        end
        else
        begin
            hit = &pos_ok;
        end
    end

endmodule

[rtl/core/scm_tracker.sv]
`include "substring_contains_matcher_top_defines.svh"

module scm_tracker
    import scm_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  step_t             step,
    input  logic              hit,
    output logic [BYTE_W-1:0] window [(NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1],
    output logic [LEN_W-1:0]  bytes_seen,
    output logic              match_next
);

    localparam int WIN_D = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;
    localparam logic [LEN_W-1:0] SEEN_MAX = LEN_W'(NEEDLE_MAX);

    logic [BYTE_W-1:0] window_reg [WIN_D];
    logic [LEN_W-1:0]  bytes_seen_reg;
    logic [LEN_W-1:0]  bytes_seen_next;
    logic              match_seen_reg;
    logic              match_seen_next;
    logic              take_byte;

    assign take_byte = step.valid && step.byte_present;

    always_comb
    begin
        match_next      = match_seen_reg || (take_byte && hit);
        bytes_seen_next = bytes_seen_reg;
        match_seen_next = match_seen_reg;
        if (step.valid)
        begin
            if (step.end_of_string)
            begin
                bytes_seen_next = '0;
                match_seen_next = 1'b0;
            end
            else if (step.byte_present)
            begin
                match_seen_next = match_next;
                if (bytes_seen_reg < SEEN_MAX)
                begin
                    bytes_seen_next = bytes_seen_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            match_seen_reg <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            match_seen_reg <= match_seen_next;
        end
    end

    // Shift line of earlier bytes, newest at tap 0.
    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            window_reg[0] <= step.text_byte;
            for (int k = 1; k < WIN_D; k++)
            begin
                window_reg[k] <= window_reg[k-1];
            end
        end
    end

    assign window     = window_reg;
    assign bytes_seen = bytes_seen_reg;

    `SCM_ASSERT_IMPLY(a_seen_bounded, 1'b1, bytes_seen_reg <= SEEN_MAX,
        "byte count beyond needle maximum")
    `SCM_ASSERT_NEXT(a_clear_on_end, step.valid && step.end_of_string,
        bytes_seen_reg == '0 && !match_seen_reg, "state not cleared at string end")
    `SCM_ASSERT_NEXT(a_count_advance,
        take_byte && !step.end_of_string && bytes_seen_reg < SEEN_MAX,
        bytes_seen_reg == $past(bytes_seen_reg) + LEN_W'(1), "byte count did not advance")

endmodule
